### rtl/door_strike_relock_timer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the door strike relock timer
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef DOOR_STRIKE_RELOCK_TIMER_MACROS_SVH
`define DOOR_STRIKE_RELOCK_TIMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

### rtl/dsrt_pkg.sv
// ---------------------------------------------------------------------------
// Door strike relock timer package
// Types, codes and constants shared by the relock timer files.
// ---------------------------------------------------------------------------
`default_nettype none

package dsrt_pkg;

  typedef enum logic [1:0] {
    OP_TICK         = 2'd0,
    OP_UNLOCK       = 2'd1,
    OP_LOCK_NOW     = 2'd2,
    OP_LOCK_DELAYED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    LS_LOCKED   = 2'd0,
    LS_UNLOCKED = 2'd1,
    LS_UNKNOWN  = 2'd2
  } lock_state_t;

  typedef enum logic [1:0] {
    DS_CLOSED  = 2'd0,
    DS_OPEN    = 2'd1,
    DS_UNKNOWN = 2'd2
  } sense_t;

  typedef enum logic [2:0] {
    REG_STRIKE_PRESENT       = 3'd0,
    REG_STRIKE_ACTIVE_LEVEL  = 3'd1,
    REG_OPEN_SENSE_PRESENT   = 3'd2,
    REG_CLOSED_SENSE_PRESENT = 3'd3,
    REG_SENSE_ACTIVE_LEVEL   = 3'd4,
    REG_DEFAULT_UNLOCK_MS    = 3'd5,
    REG_RELOCK_DELAY_MS      = 3'd6,
    REG_MIN_OPEN_RELOCK_MS   = 3'd7
  } cfg_idx_t;

  localparam logic [31:0] MS_PER_SEC     = 32'd1000;
  localparam logic [31:0] CNT_MAX        = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_DEFAULT_MS = 32'd10000;
  localparam logic [31:0] RST_RELOCK_MS  = 32'd0;
  localparam logic [31:0] RST_MIN_OPEN   = 32'd1000;

  typedef struct packed {
    logic        strike_present;
    logic        strike_active_level;
    logic        open_sense_present;
    logic        closed_sense_present;
    logic        sense_active_level;
    logic [31:0] default_unlock_ms;
    logic [31:0] relock_delay_ms;
    logic [31:0] min_open_relock_ms;
  } cfg_t;

  typedef struct packed {
    op_t         operation;
    logic        use_default_timeout;
    logic [15:0] timeout_secs;
    logic        open_sense_level;
    logic        closed_sense_level;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        strike_drive;
    lock_state_t lock_state;
    sense_t      door_sense;
    logic [31:0] time_to_relock_ms;
    logic        relock_waiting;
  } res_t;

endpackage

`default_nettype wire

### rtl/dsrt_in_if.sv
// ---------------------------------------------------------------------------
// Relock timer input channel
// Valid/ready channel carrying one command transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface dsrt_in_if;
  logic            valid;
  logic            ready;
  dsrt_pkg::op_t   operation;
  logic            use_default_timeout;
  logic [15:0]     timeout_secs;
  logic            open_sense_level;
  logic            closed_sense_level;

  modport source (
    output valid, operation, use_default_timeout, timeout_secs,
           open_sense_level, closed_sense_level,
    input  ready
  );

  modport sink (
    input  valid, operation, use_default_timeout, timeout_secs,
           open_sense_level, closed_sense_level,
    output ready
  );
endinterface

`default_nettype wire

### rtl/dsrt_out_if.sv
// ---------------------------------------------------------------------------
// Relock timer result channel
// Valid/ready channel carrying one status transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface dsrt_out_if;
  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic                    strike_drive;
  dsrt_pkg::lock_state_t   lock_state;
  dsrt_pkg::sense_t        door_sense;
  logic [31:0]             time_to_relock_ms;
  logic                    relock_waiting;

  modport source (
    output valid, accepted, strike_drive, lock_state, door_sense,
           time_to_relock_ms, relock_waiting,
    input  ready
  );

  modport sink (
    input  valid, accepted, strike_drive, lock_state, door_sense,
           time_to_relock_ms, relock_waiting,
    output ready
  );
endinterface

`default_nettype wire

### rtl/dsrt_cfg_if.sv
// ---------------------------------------------------------------------------
// Relock timer configuration channel
// Valid/ready write channel carrying a register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface dsrt_cfg_if;
  logic                 valid;
  logic                 ready;
  dsrt_pkg::cfg_idx_t   index;
  logic [31:0]          data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

### rtl/dsrt_cfg_regs.sv
// ---------------------------------------------------------------------------
// Relock timer configuration registers
// Holds the eight configuration registers written over the config channel.
// ---------------------------------------------------------------------------
`default_nettype none

module dsrt_cfg_regs (
  input  wire logic      clk,
  input  wire logic      rst_n,
  dsrt_cfg_if.sink       cfg_ch,
  output dsrt_pkg::cfg_t cfg
);

  dsrt_pkg::cfg_t cfg_r;
  dsrt_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dsrt_pkg::REG_STRIKE_PRESENT:       cfg_nxt.strike_present       = cfg_ch.data[0];
        dsrt_pkg::REG_STRIKE_ACTIVE_LEVEL:  cfg_nxt.strike_active_level  = cfg_ch.data[0];
        dsrt_pkg::REG_OPEN_SENSE_PRESENT:   cfg_nxt.open_sense_present   = cfg_ch.data[0];
        dsrt_pkg::REG_CLOSED_SENSE_PRESENT: cfg_nxt.closed_sense_present = cfg_ch.data[0];
        dsrt_pkg::REG_SENSE_ACTIVE_LEVEL:   cfg_nxt.sense_active_level   = cfg_ch.data[0];
        dsrt_pkg::REG_DEFAULT_UNLOCK_MS:    cfg_nxt.default_unlock_ms    = cfg_ch.data;
        dsrt_pkg::REG_RELOCK_DELAY_MS:      cfg_nxt.relock_delay_ms      = cfg_ch.data;
        dsrt_pkg::REG_MIN_OPEN_RELOCK_MS:   cfg_nxt.min_open_relock_ms   = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.strike_present       <= 1'b1;
      cfg_r.strike_active_level  <= 1'b1;
      cfg_r.open_sense_present   <= 1'b0;
      cfg_r.closed_sense_present <= 1'b0;
      cfg_r.sense_active_level   <= 1'b1;
      cfg_r.default_unlock_ms    <= dsrt_pkg::RST_DEFAULT_MS;
      cfg_r.relock_delay_ms      <= dsrt_pkg::RST_RELOCK_MS;
      cfg_r.min_open_relock_ms   <= dsrt_pkg::RST_MIN_OPEN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/dsrt_in_stage.sv
// ---------------------------------------------------------------------------
// Relock timer input register
// Captures one command transaction and holds it until the core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module dsrt_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  dsrt_in_if.sink         in_ch,
  input  wire logic       take,
  output logic            item_vld,
  output dsrt_pkg::item_t item
);

  logic            vld_r;
  logic            vld_nxt;
  dsrt_pkg::item_t item_r;
  logic            load;

  assign in_ch.ready = !vld_r || take;
  assign load        = in_ch.valid && in_ch.ready;
  assign vld_nxt     = load || (vld_r && !take);
  assign item_vld    = vld_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.operation           <= in_ch.operation;
      item_r.use_default_timeout <= in_ch.use_default_timeout;
      item_r.timeout_secs        <= in_ch.timeout_secs;
      item_r.open_sense_level    <= in_ch.open_sense_level;
      item_r.closed_sense_level  <= in_ch.closed_sense_level;
    end
  end

endmodule

`default_nettype wire

### rtl/dsrt_core.sv
// ---------------------------------------------------------------------------
// Relock timer core
// Lock state, elapsed counters and the result register for each command.
// ---------------------------------------------------------------------------
`default_nettype none

module dsrt_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dsrt_pkg::cfg_t  cfg,
  input  wire logic       item_vld,
  input  wire dsrt_pkg::item_t item,
  output logic            take,
  dsrt_out_if.source      out_ch
);

  logic            locked_r, locked_nxt;
  logic            pend_r, pend_nxt;
  logic [31:0]     dur_r, dur_nxt;
  logic [31:0]     su_r, su_nxt;
  logic [31:0]     sr_r, sr_nxt;
  logic            out_vld_r, out_vld_nxt;
  dsrt_pkg::res_t  res_r, res_nxt;

  logic            garage;
  logic            open_hit;
  logic            closed_hit;
  dsrt_pkg::sense_t sense;
  logic [31:0]     su_inc;
  logic [31:0]     sr_inc;
  logic [31:0]     secs_ms;
  logic            accepted;

  assign take        = item_vld && (!out_vld_r || out_ch.ready);
  assign out_vld_nxt = take || (out_vld_r && !out_ch.ready);

  assign garage     = cfg.closed_sense_present;
  assign open_hit   = item.open_sense_level == cfg.sense_active_level;
  assign closed_hit = garage && (item.closed_sense_level == cfg.sense_active_level);

  always_comb begin
    if (!cfg.open_sense_present) begin
      sense = dsrt_pkg::DS_UNKNOWN;
    end else if (open_hit) begin
      sense = dsrt_pkg::DS_OPEN;
    end else if (garage && !closed_hit) begin
      sense = dsrt_pkg::DS_UNKNOWN;
    end else begin
      sense = dsrt_pkg::DS_CLOSED;
    end
  end

  assign su_inc  = (su_r == dsrt_pkg::CNT_MAX) ? su_r : su_r + 32'd1;
  assign sr_inc  = (sr_r == dsrt_pkg::CNT_MAX) ? sr_r : sr_r + 32'd1;
  assign secs_ms = 32'(item.timeout_secs) * dsrt_pkg::MS_PER_SEC;

  always_comb begin
    locked_nxt = locked_r;
    pend_nxt   = pend_r;
    dur_nxt    = dur_r;
    su_nxt     = su_r;
    sr_nxt     = sr_r;
    accepted   = 1'b1;
    unique case (item.operation)
      dsrt_pkg::OP_TICK: begin
        su_nxt = su_inc;
        sr_nxt = sr_inc;
        if (!locked_r) begin
          if (garage) begin
            if (su_inc > dur_r) begin
              locked_nxt = 1'b1;
            end
          end else if (sense == dsrt_pkg::DS_OPEN && su_inc > cfg.min_open_relock_ms) begin
            locked_nxt = 1'b1;
          end else if (su_inc > dur_r) begin
            locked_nxt = 1'b1;
          end else if (pend_r && sr_inc > cfg.relock_delay_ms) begin
            locked_nxt = 1'b1;
            pend_nxt   = 1'b0;
          end
        end
      end
      dsrt_pkg::OP_UNLOCK: begin
        if (!cfg.strike_present) begin
          accepted = 1'b0;
        end else begin
          locked_nxt = 1'b0;
          pend_nxt   = 1'b0;
          dur_nxt    = item.use_default_timeout ? cfg.default_unlock_ms : secs_ms;
          su_nxt     = 32'd0;
        end
      end
      dsrt_pkg::OP_LOCK_NOW: begin
        locked_nxt = 1'b1;
      end
      dsrt_pkg::OP_LOCK_DELAYED: begin
        pend_nxt = 1'b1;
        sr_nxt   = 32'd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_nxt.accepted     = accepted;
    res_nxt.strike_drive = locked_nxt ? !cfg.strike_active_level : cfg.strike_active_level;
    if (garage) begin
      unique case (sense)
        dsrt_pkg::DS_OPEN:   res_nxt.lock_state = dsrt_pkg::LS_UNLOCKED;
        dsrt_pkg::DS_CLOSED: res_nxt.lock_state = dsrt_pkg::LS_LOCKED;
        default:             res_nxt.lock_state = dsrt_pkg::LS_UNKNOWN;
      endcase
    end else begin
      res_nxt.lock_state = locked_nxt ? dsrt_pkg::LS_LOCKED : dsrt_pkg::LS_UNLOCKED;
    end
    res_nxt.door_sense        = sense;
    res_nxt.time_to_relock_ms = (su_nxt >= dur_nxt) ? 32'd0 : dur_nxt - su_nxt;
    res_nxt.relock_waiting    = pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r  <= 1'b1;
      pend_r    <= 1'b0;
      dur_r     <= 32'd0;
      su_r      <= 32'd0;
      sr_r      <= 32'd0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (take) begin
        locked_r <= locked_nxt;
        pend_r   <= pend_nxt;
        dur_r    <= dur_nxt;
        su_r     <= su_nxt;
        sr_r     <= sr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.accepted          = res_r.accepted;
  assign out_ch.strike_drive      = res_r.strike_drive;
  assign out_ch.lock_state        = res_r.lock_state;
  assign out_ch.door_sense        = res_r.door_sense;
  assign out_ch.time_to_relock_ms = res_r.time_to_relock_ms;
  assign out_ch.relock_waiting    = res_r.relock_waiting;

endmodule

`default_nettype wire

### rtl/door_strike_relock_timer.sv
// ---------------------------------------------------------------------------
// Door strike relock timer
// Each command transaction on in_ch is a one-millisecond tick, an unlock,
// an immediate lock or a delayed lock request, together with the raw open
// and closed sensor levels. Each command yields exactly one status
// transaction on out_ch with the strike drive, lock and door states, the
// time left before relock and the pending-relock flag.
// Configuration registers are written over cfg_ch, which is always ready;
// they should only be written while no command is in flight.
// A command is registered in the input register on entry, and its status
// is registered in the result register when the core takes the command.
// One command is taken every cycle while out_ch is ready; the state update
// of the core is combinational.
// When out_ch stalls, the status register holds and the input register can
// still take one more command before in_ch.ready drops.
// Reset returns the configuration and state registers to their defaults,
// the door to locked, both elapsed counters to zero, and empties the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

`include "door_strike_relock_timer_macros.svh"

module door_strike_relock_timer (
  input  wire logic clk,
  input  wire logic rst_n,
  dsrt_in_if.sink   in_ch,
  dsrt_out_if.source out_ch,
  dsrt_cfg_if.sink  cfg_ch
);

  dsrt_pkg::cfg_t  cfg;
  dsrt_pkg::item_t item;
  logic            item_vld;
  logic            take;

  dsrt_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  dsrt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  dsrt_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .item_vld (item_vld),
    .item     (item),
    .take     (take),
    .out_ch   (out_ch)
  );

  `DSRT_ASSERT_NEXT(a_in_captured, clk, rst_n, in_ch.valid && in_ch.ready, item_vld)
  `DSRT_ASSERT_NEXT(a_item_to_out, clk, rst_n, item_vld && !out_ch.valid, out_ch.valid)
  `DSRT_ASSERT_SAME(a_unknown_lock, clk, rst_n, out_ch.valid && out_ch.lock_state == dsrt_pkg::LS_UNKNOWN, out_ch.door_sense == dsrt_pkg::DS_UNKNOWN)

endmodule

`default_nettype wire
